// ===== rtl/anp_pkg.sv =====
// Shared types, character codes and state codes for the ABC note token parser.
package anp_pkg;

  localparam logic [7:0] ChLf     = 8'd10;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpG    = 8'h47;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoG    = 8'h67;
  localparam logic [7:0] ChRest   = 8'h7A;
  localparam logic [7:0] ChDig0   = 8'h30;
  localparam logic [7:0] ChDig9   = 8'h39;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] LowerOfs = 8'd7;

  // line phase codes
  localparam logic [1:0] PhStart  = 2'd0;
  localparam logic [1:0] PhHeld   = 2'd1;
  localparam logic [1:0] PhBody   = 2'd2;
  localparam logic [1:0] PhHeader = 2'd3;

  // pending note codes
  localparam logic [1:0] PkNone   = 2'd0;
  localparam logic [1:0] PkNote   = 2'd1;
  localparam logic [1:0] PkDigit  = 2'd2;

  localparam logic signed [4:0] PitchRest = -5'sd1;
  localparam logic [3:0]        DurDflt   = 4'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [4:0] pitch;
    logic [3:0]        duration;
  } anp_pend_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] held;
    anp_pend_t  pend;
  } anp_state_t;

  typedef struct packed {
    logic              tied;
    logic [3:0]        duration;
    logic signed [4:0] pitch;
  } anp_note_t;

  function automatic logic is_tie_letter(input logic [7:0] b);
    return ((b >= ChUpA) && (b <= ChUpG)) || ((b >= ChLoA) && (b <= ChLoG));
  endfunction

endpackage

// ===== rtl/anp_step.sv =====
// Next-state and token logic for one text byte.
module anp_step
  import anp_pkg::*;
(
  input  anp_state_t state_i,
  input  logic [7:0] byte_i,
  output anp_state_t state_o,
  output logic       emit_o,
  output anp_note_t  note_o
);

  typedef struct packed {
    anp_pend_t pend;
    logic      emit;
    anp_note_t note;
  } anp_feed_t;

  // One body byte against the pending note.
  function automatic anp_feed_t feed(input anp_pend_t pend, input logic [7:0] b);
    anp_feed_t  r;
    logic [7:0] ofs;
    r.pend          = pend;
    r.emit          = 1'b0;
    r.note.pitch    = pend.pitch;
    r.note.duration = pend.duration;
    r.note.tied     = is_tie_letter(b);
    ofs             = '0;
    if ((pend.kind == PkNote) && (b >= ChDig0) && (b <= ChDig9)) begin
      r.pend.duration = b[3:0];
      r.pend.kind     = PkDigit;
    end else begin
      if (pend.kind != PkNone) begin
        r.emit      = 1'b1;
        r.pend.kind = PkNone;
      end
      if ((b >= ChUpA) && (b <= ChUpG)) begin
        ofs             = b - ChUpA;
        r.pend.pitch    = ofs[4:0];
        r.pend.duration = DurDflt;
        r.pend.kind     = PkNote;
      end else if ((b >= ChLoA) && (b <= ChLoG)) begin
        ofs             = b - ChLoA + LowerOfs;
        r.pend.pitch    = ofs[4:0];
        r.pend.duration = DurDflt;
        r.pend.kind     = PkNote;
      end else if (b == ChRest) begin
        r.pend.pitch    = PitchRest;
        r.pend.duration = DurDflt;
        r.pend.kind     = PkNote;
      end
    end
    return r;
  endfunction

  anp_feed_t f_held;   // held first byte against current pending
  anp_feed_t f_cur;    // current byte after the held byte
  anp_feed_t f_body;   // current byte in a body line

  assign f_held = feed(state_i.pend, state_i.held);
  assign f_cur  = feed(f_held.pend, byte_i);
  assign f_body = feed(state_i.pend, byte_i);

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    note_o  = f_body.note;
    if (byte_i == ChLf) begin
      // line end flushes any pending note untied
      note_o.tied = 1'b0;
      if (state_i.phase == PhHeld) begin
        emit_o          = f_held.pend.kind != PkNone;
        note_o.pitch    = f_held.pend.pitch;
        note_o.duration = f_held.pend.duration;
      end else if (state_i.phase == PhBody) begin
        emit_o          = state_i.pend.kind != PkNone;
        note_o.pitch    = state_i.pend.pitch;
        note_o.duration = state_i.pend.duration;
      end
      state_o.phase     = PhStart;
      state_o.pend.kind = PkNone;
    end else begin
      unique case (state_i.phase)
        PhStart: begin
          state_o.held  = byte_i;
          state_o.phase = PhHeld;
        end
        PhHeld: begin
          if (byte_i == ChColon) begin
            state_o.phase = PhHeader;
          end else begin
            state_o.phase = PhBody;
            state_o.pend  = f_cur.pend;
            emit_o        = f_cur.emit;
            note_o        = f_cur.note;
          end
        end
        PhBody: begin
          state_o.pend = f_body.pend;
          emit_o       = f_body.emit;
          note_o       = f_body.note;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/abc_note_token_parser.sv =====
// Top level of the ABC note token parser: input register, parse state, output register.
//
//  channel   dir  tdata fields (lsb first)                   beat meaning
//  s_axis    in   char_code[7:0]                             one text byte, 10 = line end
//  m_axis    out  pitch[4:0] duration[8:5] tied[9] pad[15:10] one note or rest token
//
// One byte per cycle sustained unless the output stalls. A byte is registered in the input
// register, then the parse logic updates the line state and may load a token into the output
// register. Tokens trail their letter by one or two bytes (digit and tie lookahead).
// Reset (rst_ni low, async) returns to line start with nothing pending.
// An output stall only holds the input register when its byte makes a token.
module abc_note_token_parser
  import anp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // pitch[4:0], duration[8:5], tied[9], zeros
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;

  // parse state
  anp_state_t st_q, st_d;

  // output register
  logic      out_valid_q, out_valid_d;
  anp_note_t out_note_q, out_note_d;

  logic       step_emit;
  anp_note_t  step_note;
  anp_state_t step_state;
  logic       out_free;
  logic       in_adv;     // byte in the input register is consumed this cycle
  logic       in_take;

  anp_step u_step (
    .state_i (st_q),
    .byte_i  (in_byte_q),
    .state_o (step_state),
    .emit_o  (step_emit),
    .note_o  (step_note)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_adv          = in_valid_q && (!step_emit || out_free);
  assign s_axis_tready_o = !in_valid_q || in_adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (in_take) begin
      in_valid_d = 1'b1;
      in_byte_d  = s_axis_tdata_i;
    end else if (in_adv) begin
      in_valid_d = 1'b0;
    end
  end

  assign st_d = in_adv ? step_state : st_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_note_d  = out_note_q;
    if (in_adv && step_emit) begin
      out_valid_d = 1'b1;
      out_note_d  = step_note;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      st_q.phase         <= PhStart;
      st_q.held          <= '0;
      st_q.pend.kind     <= PkNone;
      st_q.pend.pitch    <= '0;
      st_q.pend.duration <= DurDflt;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q  <= in_byte_d;
    out_note_q <= out_note_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_note_q.tied, out_note_q.duration, out_note_q.pitch};

  // line end always leaves the parser at line start with nothing pending
  a_lf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && (in_byte_q == ChLf)) |=> ((st_q.phase == PhStart) && (st_q.pend.kind == PkNone)))
    else $error("line end did not clear parse state");

  // header lines never make tokens
  a_header_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (st_q.phase == PhHeader)) |-> !step_emit)
    else $error("token from header line");

  // a tie is only reported when the current byte is a note letter
  a_tie_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && step_emit && step_note.tied) |-> is_tie_letter(in_byte_q))
    else $error("tie without following letter");

  // a held byte waits for the output register and is not dropped
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_adv) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input byte lost during stall");

  // parse state moves only when a byte is consumed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_adv |=> $stable(st_q))
    else $error("parse state changed without a byte");

endmodule

// ===== verif/abc_note_token_parser_test.sv =====
// Self-checking testbench for the ABC note token parser: byte stream in, note tokens out.
module abc_note_token_parser_test;
  import anp_pkg::*;

  localparam int          QuietLimit  = 1000;  // cycles with no beat on either side
  localparam int          DrainCycles = 12;
  localparam int          RandomBytes = 580;
  localparam int          HoldCycles  = 120;
  localparam int          PrintCap    = 40;
  localparam logic [7:0]  ChCr        = 8'h0D;
  localparam logic [15:0] PadMask     = 16'hFC00;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  // shared by the sender, the receiver and the test tasks
  bit calm = 1'b0;   // no random idle cycles on either side while set
  int hold_cycles = 0;

  // parser state as seen by the predictor
  logic [1:0]        ln_phase = PhStart;
  logic [7:0]        ln_first = 8'h00;
  logic [1:0]        nt_kind = PkNone;
  logic signed [4:0] nt_pitch = 5'sd0;
  logic [3:0]        nt_dur = DurDflt;
  anp_note_t         tokens_due[$];

  int err_count = 0;
  int bytes_sent = 0;
  int lines_sent = 0;
  int header_lines = 0;
  int tokens_checked = 0;
  int tied_seen = 0;
  int rests_seen = 0;

  abc_note_token_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  // 0-13 for the pitch letters, -1 for a rest, -2 for anything else
  function automatic int letter_code(input logic [7:0] b);
    if (b >= ChUpA && b <= ChUpG) return int'(b - ChUpA);
    if (b >= ChLoA && b <= ChLoG) return int'(b - ChLoA) + int'(LowerOfs);
    if (b == ChRest) return -1;
    return -2;
  endfunction

  function automatic void queue_token(input logic tied);
    anp_note_t t;
    t.pitch    = nt_pitch;
    t.duration = nt_dur;
    t.tied     = tied;
    tokens_due = {tokens_due, t};
    nt_kind = PkNone;
  endfunction

  function automatic void body_byte(input logic [7:0] b);
    int code;
    code = letter_code(b);
    if (nt_kind == PkNote && b >= ChDig0 && b <= ChDig9) begin
      nt_dur  = 4'(b - ChDig0);
      nt_kind = PkDigit;
      return;
    end
    // a pending note is released by any other byte; only a pitch letter ties it
    if (nt_kind != PkNone) queue_token(code >= 0);
    if (code >= -1) begin
      nt_pitch = 5'(code);
      nt_dur   = DurDflt;
      nt_kind  = PkNote;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    if (b == ChLf) begin
      lines_sent++;
      // a lone first byte is a one-byte line
      if (ln_phase == PhHeld) body_byte(ln_first);
      if ((ln_phase == PhHeld || ln_phase == PhBody) && nt_kind != PkNone) queue_token(1'b0);
      ln_phase = PhStart;
      nt_kind  = PkNone;
    end else begin
      case (ln_phase)
        PhStart: begin
          ln_first = b;
          ln_phase = PhHeld;
        end
        PhHeld: begin
          if (b == ChColon) begin
            ln_phase = PhHeader;
            header_lines++;
          end else begin
            ln_phase = PhBody;
            body_byte(ln_first);
            body_byte(b);
          end
        end
        PhBody: body_byte(b);
        default: ;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (err_count < PrintCap) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_token(input logic [15:0] d);
    anp_note_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("token 0x%04h arrived with none expected", d));
      return;
    end
    want = tokens_due.pop_front();
    tokens_checked++;
    if (d[9]) tied_seen++;
    if ($signed(d[4:0]) == PitchRest) rests_seen++;
    if (d[4:0] !== want.pitch)
      report_mismatch($sformatf("pitch %0d, expected %0d", $signed(d[4:0]), want.pitch));
    if (d[8:5] !== want.duration)
      report_mismatch($sformatf("duration %0d, expected %0d", d[8:5], want.duration));
    if (d[9] !== want.tied)
      report_mismatch($sformatf("tied %b, expected %b", d[9], want.tied));
    if ((d & PadMask) !== 16'h0000)
      report_mismatch($sformatf("pad bits not zero in 0x%04h", d));
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_n && m_axis_tvalid_o && m_tready) check_token(m_axis_tdata_o);
    end
  end

  // receiver: random stalls, or a counted hold-off when a test asks for one
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // watchdog: ends the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no beat for %0d cycles, %0d tokens outstanding",
             QuietLimit, tokens_due.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // returns at the rising edge where the byte was taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 10) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  // any byte but a line end; now and then one just outside a letter or digit range
  function automatic logic [7:0] noise_byte();
    string edges;
    logic [7:0] b;
    edges = "@H`hy{/:";
    if ($urandom_range(99) < 30) return edges[$urandom_range(edges.len() - 1)];
    do b = 8'($urandom_range(255)); while (b == ChLf);
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'(ChDig0 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] note_byte();
    string letters;
    letters = "ABCDEFGabcdefgz";
    return letters[$urandom_range(letters.len() - 1)];
  endfunction

  task automatic send_random_line();
    int pick;
    int r;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // header: any first byte, colon, then text that must be skipped
      send_byte(noise_byte());
      send_byte(ChColon);
      repeat ($urandom_range(8)) send_byte($urandom_range(1) ? note_byte() : noise_byte());
    end else if (pick < 18) begin
      // raw bytes, line ends included
      repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(255)));
    end else if (pick < 26) begin
      // empty line or a single byte
      if ($urandom_range(1)) send_byte($urandom_range(2) ? note_byte() : noise_byte());
    end else begin
      repeat ($urandom_range(1, 10)) begin
        send_byte(note_byte());
        r = $urandom_range(99);
        if (r < 45) send_byte(digit_byte());
        if (r < 8) send_byte(digit_byte());
        if ($urandom_range(99) < 10) send_byte(noise_byte());
      end
    end
    send_byte(ChLf);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_header_and_short_lines();
    send_text("X:C");   // header holding a note letter
    send_byte(ChLf);
    send_byte(ChLf);    // empty line
    send_text("g");     // one-byte line, top pitch
    send_byte(ChLf);
    send_text("C:a");   // note letter as first byte of a header
    send_byte(ChLf);
  endtask

  task automatic test_durations_and_ties();
    // A dur 0 tied, G untied before the rest, rest dur 9 tied, a closed by line end
    send_text("A0Gz9a");
    send_byte(ChLf);
  endtask

  task automatic test_ignored_bytes();
    send_text("g12");   // second digit releases the note untied
    send_byte(ChCr);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(ChLf);
  endtask

  task automatic test_output_backpressure();
    calm = 1'b1;
    hold_cycles = HoldCycles;
    // every byte after the first makes a token, so the parser backs up onto its input
    repeat (20) send_text("aB");
    send_byte(ChLf);
    calm = 1'b0;
  endtask

  task automatic test_random_lines();
    int start;
    start = bytes_sent;
    calm = 1'b1;
    while (bytes_sent - start < 150) send_random_line();
    calm = 1'b0;
    while (bytes_sent - start < RandomBytes) send_random_line();
  endtask

  task automatic test_unterminated_tail();
    // last line left open: its final note must never come out
    send_text("cd2e");
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    test_header_and_short_lines();
    test_durations_and_ties();
    test_ignored_bytes();
    test_output_backpressure();
    test_random_lines();
    test_unterminated_tail();

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run: %0d bytes in %0d closed lines, %0d of them headers; one line left open.",
             bytes_sent, lines_sent, header_lines);
    $display("Checked %0d tokens (%0d tied, %0d rests), %0d mismatches.",
             tokens_checked, tied_seen, rests_seen, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
